/* rtl/core/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants, codes and types for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH    = 16;
  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_REAR  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_REAR   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_LIST       = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_IN,
    CELL_SHIFT_OUT,
    CELL_APPEND,
    CELL_DROP_REAR,
    CELL_ROTATE
  } dq_op_t;

  typedef struct packed {
    dq_op_t              op;
    logic [DATA_W-1:0]   value;
  } dq_ctrl_t;

  typedef struct packed {
    logic                valid;
    logic [DATA_W-1:0]   data;
  } dq_link_t;

endpackage

/* rtl/core/dq_cell.sv */
// ----------------------------------------------------------------------------
// dq_cell
// One storage cell of the queue chain. Holds one entry and its valid flag,
// and takes data from either neighbour as the chain shifts or rotates.
// ----------------------------------------------------------------------------
module dq_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  dq_pkg::dq_ctrl_t          ctrl,
  input  dq_pkg::dq_link_t          left,
  input  dq_pkg::dq_link_t          right,
  input  dq_pkg::dq_link_t          front,
  output dq_pkg::dq_link_t          link,
  output logic [dq_pkg::DATA_W-1:0] rear_data
);
  import dq_pkg::*;

  logic              valid;
  logic [DATA_W-1:0] data;
  logic              is_rear;

  assign is_rear   = valid && !right.valid;
  assign link      = '{valid: valid, data: data};
  assign rear_data = is_rear ? data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctrl.op)
        CELL_SHIFT_IN: begin
          valid <= left.valid;
        end
        CELL_SHIFT_OUT: begin
          valid <= right.valid;
        end
        CELL_APPEND: begin
          if (left.valid && !valid) begin
            valid <= 1'b1;
          end
        end
        CELL_DROP_REAR: begin
          if (is_rear) begin
            valid <= 1'b0;
          end
        end
        default: begin
          valid <= valid;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_SHIFT_IN: begin
        data <= left.data;
      end
      CELL_SHIFT_OUT: begin
        data <= right.data;
      end
      CELL_APPEND: begin
        if (left.valid && !valid) begin
          data <= ctrl.value;
        end
      end
      CELL_ROTATE: begin
        if (right.valid) begin
          data <= right.data;
        end else if (valid) begin
          data <= front.data;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

/* rtl/core/double_ended_queue_top.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Double-ended queue of signed 32-bit values built as a chain of cells.
// ----------------------------------------------------------------------------
// Entries sit in order from front (cell 0) to rear in a row of DEPTH cells.
// Push front, push rear, pop front and pop rear each give one result; an item
// with an unused func code gives none. After acceptance a listing sends out one
// stored entry per rotation: while the output is not stalled the chain rotates
// by one cell per cycle and the front cell is sent out each time, so after count
// rotations the order is back where it started. Input is stalled while a listing
// runs and while the output register holds a result that has not been taken.
module double_ended_queue_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dq_pkg::FUNC_W-1:0]          func,
  input  logic signed [dq_pkg::DATA_W-1:0]   push_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [dq_pkg::DATA_W-1:0]   data_out,
  output logic [dq_pkg::STATUS_W-1:0]        status,
  output logic                               last
);
  import dq_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  remaining;
  dq_ctrl_t          ctrl;
  dq_link_t          link [DEPTH];
  logic [DATA_W-1:0] cell_rear [DEPTH];
  logic [DATA_W-1:0] rear_data;
  logic [DEPTH-1:0]  valid_vec;
  logic              accept;
  logic              out_free;
  logic              full;
  logic              empty;

  assign in_stall = (state == ST_LIST) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign full     = link[DEPTH-1].valid;
  assign empty    = !link[0].valid;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      dq_link_t left_in;
      dq_link_t right_in;
      if (g == 0) begin : g_first
        assign left_in = '{valid: 1'b1, data: push_value};
      end else begin : g_mid
        assign left_in = link[g-1];
      end
      if (g == DEPTH - 1) begin : g_end
        assign right_in = '0;
      end else begin : g_next
        assign right_in = link[g+1];
      end
      dq_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .left      (left_in),
        .right     (right_in),
        .front     (link[0]),
        .link      (link[g]),
        .rear_data (cell_rear[g])
      );
      assign valid_vec[g] = link[g].valid;
    end
  endgenerate

  always_comb begin
    rear_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_data = rear_data | cell_rear[i];
    end
  end

  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.value = push_value;
    if (accept) begin
      case (func)
        FUNC_PUSH_FRONT: if (!full)  ctrl.op = CELL_SHIFT_IN;
        FUNC_PUSH_REAR:  if (!full)  ctrl.op = CELL_APPEND;
        FUNC_POP_FRONT:  if (!empty) ctrl.op = CELL_SHIFT_OUT;
        FUNC_POP_REAR:   if (!empty) ctrl.op = CELL_DROP_REAR;
        default:         ctrl.op = CELL_HOLD;
      endcase
    end else if (state == ST_LIST && out_free) begin
      ctrl.op = CELL_ROTATE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        case (func)
          FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
            out_valid <= 1'b1;
            data_out  <= '0;
            last      <= 1'b1;
            status    <= full ? STATUS_FULL : STATUS_OK;
            if (!full) begin
              count <= count + CNT_W'(1);
            end
          end
          FUNC_POP_FRONT, FUNC_POP_REAR: begin
            out_valid <= 1'b1;
            last      <= 1'b1;
            if (empty) begin
              data_out <= '0;
              status   <= STATUS_EMPTY;
            end else begin
              data_out <= (func == FUNC_POP_FRONT) ? link[0].data : rear_data;
              status   <= STATUS_OK;
              count    <= count - CNT_W'(1);
            end
          end
          FUNC_LIST: begin
            if (empty) begin
              out_valid <= 1'b1;
              data_out  <= '0;
              status    <= STATUS_EMPTY;
              last      <= 1'b1;
            end else begin
              state     <= ST_LIST;
              remaining <= count;
            end
          end
          default: begin
            state <= state;
          end
        endcase
      end else if (state == ST_LIST && out_free) begin
        out_valid <= 1'b1;
        data_out  <= link[0].data;
        status    <= STATUS_OK;
        last      <= (remaining == CNT_W'(1));
        remaining <= remaining - CNT_W'(1);
        if (remaining == CNT_W'(1)) begin
          state <= ST_IDLE;
        end
      end
    end
  end

  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("entry count disagrees with occupied cells");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= DEPTH)
    else $error("entry count beyond depth");

  a_list_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_LIST |-> remaining != '0 && !empty)
    else $error("listing running with nothing left");

  a_list_keeps_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_LIST |=> $stable(count))
    else $error("entry count changed during listing");

endmodule
